FILE: sv/triangle_circumcircle_assert.svh
// Assertion macros for the triangle circumcircle block.
// Used by RTL files in this folder; expects clk and rst in scope.
`ifndef TRIANGLE_CIRCUMCIRCLE_ASSERT_SVH
`define TRIANGLE_CIRCUMCIRCLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcc_pkg.sv
// Types and width constants for the triangle circumcircle block.
// No dependencies; used by tcc_front and the top level.
`default_nettype none

package tcc_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 1;
  localparam int N_W      = 2 * DOT_W;
  localparam int N123_W   = N_W + 2;
  localparam int WSUM_W   = N_W + 1;
  localparam int MUL_W    = COORD_W + WSUM_W;
  localparam int NUM_W    = MUL_W + 2;
  localparam int DEN_W    = N123_W + 1;
  localparam int CQ_W     = 33;
  localparam int SIDE_W   = DOT_W;
  localparam int SP_W     = 2 * SIDE_W;
  localparam int P_W      = 3 * SIDE_W;
  localparam int RD_W     = DEN_W + 1;
  localparam int RQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int OUT_W    = 32;
  localparam int FRONT_STAGES = 9;

  localparam logic [OUT_W-1:0] S32_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] S32_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] U32_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
    logic signed [COORD_W-1:0] point_c_x;
    logic signed [COORD_W-1:0] point_c_y;
  } tcc_req_t;

  typedef struct packed {
    logic                     is_valid;
    logic                     saturated;
    logic signed [OUT_W-1:0]  center_x;
    logic signed [OUT_W-1:0]  center_y;
    logic        [OUT_W-1:0]  radius;
  } tcc_rsp_t;

  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic ovf_r;
  } tcc_flags_t;

  typedef struct packed {
    tcc_flags_t        flags;
    logic [DEN_W-1:0]  dc;
    logic [DEN_W-1:0]  x_rem;
    logic [CQ_W-1:0]   x_sh;
    logic [DEN_W-1:0]  y_rem;
    logic [CQ_W-1:0]   y_sh;
    logic [RD_W-1:0]   r_rem;
    logic [RQ_W-1:0]   r_sh;
    logic [RD_W-1:0]   dr;
  } tcc_front_t;

  typedef struct packed {
    tcc_flags_t        flags;
    logic [DEN_W-1:0]  dc;
    logic [RD_W-1:0]   r_rem;
    logic [RQ_W-1:0]   r_sh;
    logic [RD_W-1:0]   dr;
  } tcc_p1_t;

  typedef struct packed {
    tcc_flags_t        flags;
    logic [CQ_W-1:0]   qx;
    logic [CQ_W-1:0]   qy;
    logic [RD_W-1:0]   dr;
  } tcc_p2_t;

  typedef struct packed {
    tcc_flags_t        flags;
    logic [CQ_W-1:0]   qx;
    logic [CQ_W-1:0]   qy;
  } tcc_p3_t;

  // Clip a magnitude quotient with sign to signed 32 bits; MSB of result is the clip flag
  function automatic logic [OUT_W:0] sat_center(input logic [CQ_W-1:0] q,
                                                input logic neg, input logic ovf);
    logic [CQ_W-1:0] nq;
    nq = ~q + CQ_W'(1);
    if (ovf) begin
      sat_center = {1'b1, (neg ? S32_MIN : S32_MAX)};
    end else if (neg) begin
      if (q > {1'b0, S32_MIN}) sat_center = {1'b1, S32_MIN};
      else sat_center = {1'b0, nq[OUT_W-1:0]};
    end else begin
      if (q > {1'b0, S32_MAX}) sat_center = {1'b1, S32_MAX};
      else sat_center = {1'b0, q[OUT_W-1:0]};
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/tcc_front.sv
// Front arithmetic of the circumcircle block: dot products, weights,
// numerators and divisor setup over nine registered stages. Uses tcc_pkg.
`default_nettype none

module tcc_front (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire tcc_pkg::tcc_req_t req,
  output tcc_pkg::tcc_front_t    res
);

  localparam int CW = tcc_pkg::COORD_W;
  localparam int DW = tcc_pkg::DIFF_W;
  localparam int PW = tcc_pkg::PROD_W;
  localparam int OW = tcc_pkg::DOT_W;
  localparam int NW = tcc_pkg::N_W;
  localparam int N3 = tcc_pkg::N123_W;
  localparam int WW = tcc_pkg::WSUM_W;
  localparam int UW = tcc_pkg::NUM_W;
  localparam int EW = tcc_pkg::DEN_W;
  localparam int QW = tcc_pkg::CQ_W;
  localparam int SW = tcc_pkg::SIDE_W;
  localparam int XW = tcc_pkg::SP_W;
  localparam int BW = tcc_pkg::P_W;
  localparam int RW = tcc_pkg::RD_W;
  localparam int RQ = tcc_pkg::RQ_W;
  localparam int WL = 36;
  localparam int WH = WW - WL;
  localparam int HW = CW + WH;
  localparam int LW = CW + WL + 1;

  // stage 1
  logic signed [CW-1:0] ax1, ay1, bx1, by1, cx1, cy1;
  logic signed [DW-1:0] eabx, eaby, ebcx, ebcy, ecax, ecay;
  // stage 2
  logic signed [CW-1:0] ax2, ay2, bx2, by2, cx2, cy2;
  logic signed [PW-1:0] pa, pb, pc, pd, pe, pf;
  // stage 3
  logic signed [CW-1:0] ax3, ay3, bx3, by3, cx3, cy3;
  logic signed [OW-1:0] dca, dba, dcb;
  // stage 4
  logic signed [CW-1:0] ax4, ay4, bx4, by4, cx4, cy4;
  logic signed [NW-1:0] n1, n2, n3;
  logic [SW-1:0] sab, sbc, sca4;
  // stage 5
  logic signed [CW-1:0] ax5, ay5, bx5, by5, cx5, cy5;
  logic signed [N3-1:0] n123_5;
  logic signed [WW-1:0] wa, wb, wc;
  logic [XW-1:0] sp;
  logic [SW-1:0] sca5;
  // stage 6
  logic signed [HW-1:0] hxa, hxb, hxc, hya, hyb, hyc;
  logic signed [LW-1:0] lxa, lxb, lxc, lya, lyb, lyc;
  logic [XW-1:0] ph, pl;
  logic signed [N3-1:0] n123_6;
  // stage 7
  logic signed [UW-1:0] numx, numy;
  logic signed [EW-1:0] den;
  logic [BW-1:0] p7;
  // stage 8
  logic [UW-1:0] absx, absy;
  logic [EW-1:0] absd;
  logic negx, negy, zero8;
  logic [BW-1:0] p8;

  // Take edge vectors
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= req.point_a_x; ay1 <= req.point_a_y;
      bx1 <= req.point_b_x; by1 <= req.point_b_y;
      cx1 <= req.point_c_x; cy1 <= req.point_c_y;
      eabx <= {req.point_b_x[CW-1], req.point_b_x} - {req.point_a_x[CW-1], req.point_a_x};
      eaby <= {req.point_b_y[CW-1], req.point_b_y} - {req.point_a_y[CW-1], req.point_a_y};
      ebcx <= {req.point_c_x[CW-1], req.point_c_x} - {req.point_b_x[CW-1], req.point_b_x};
      ebcy <= {req.point_c_y[CW-1], req.point_c_y} - {req.point_b_y[CW-1], req.point_b_y};
      ecax <= {req.point_a_x[CW-1], req.point_a_x} - {req.point_c_x[CW-1], req.point_c_x};
      ecay <= {req.point_a_y[CW-1], req.point_a_y} - {req.point_c_y[CW-1], req.point_c_y};
    end
  end

  // Multiply edge components
  always_ff @(posedge clk) begin
    if (en) begin
      ax2 <= ax1; ay2 <= ay1; bx2 <= bx1; by2 <= by1; cx2 <= cx1; cy2 <= cy1;
      pa <= ecax * eabx;
      pb <= ecay * eaby;
      pc <= ebcx * eabx;
      pd <= ebcy * eaby;
      pe <= ecax * ebcx;
      pf <= ecay * ebcy;
    end
  end

  // Sum into corner dot products (each is minus the edge product sum)
  always_ff @(posedge clk) begin
    if (en) begin
      ax3 <= ax2; ay3 <= ay2; bx3 <= bx2; by3 <= by2; cx3 <= cx2; cy3 <= cy2;
      dca <= -(OW'(pa) + OW'(pb));
      dba <= -(OW'(pc) + OW'(pd));
      dcb <= -(OW'(pe) + OW'(pf));
    end
  end

  // Pairwise products and squared side lengths
  always_ff @(posedge clk) begin
    if (en) begin
      ax4 <= ax3; ay4 <= ay3; bx4 <= bx3; by4 <= by3; cx4 <= cx3; cy4 <= cy3;
      n1   <= NW'(dba) * NW'(dcb);
      n2   <= NW'(dcb) * NW'(dca);
      n3   <= NW'(dca) * NW'(dba);
      sab  <= SW'(dca + dba);
      sbc  <= SW'(dba + dcb);
      sca4 <= SW'(dcb + dca);
    end
  end

  // Vertex weights, total and first side product
  always_ff @(posedge clk) begin
    if (en) begin
      ax5 <= ax4; ay5 <= ay4; bx5 <= bx4; by5 <= by4; cx5 <= cx4; cy5 <= cy4;
      n123_5 <= N3'(n1) + N3'(n2) + N3'(n3);
      wa     <= WW'(n2) + WW'(n3);
      wb     <= WW'(n3) + WW'(n1);
      wc     <= WW'(n1) + WW'(n2);
      sp     <= XW'(sab) * XW'(sbc);
      sca5   <= sca4;
    end
  end

  // Weighted vertex terms as high and low weight halves, and split side product
  always_ff @(posedge clk) begin
    if (en) begin
      hxa <= HW'(ax5) * HW'($signed(wa[WW-1:WL]));
      hxb <= HW'(bx5) * HW'($signed(wb[WW-1:WL]));
      hxc <= HW'(cx5) * HW'($signed(wc[WW-1:WL]));
      hya <= HW'(ay5) * HW'($signed(wa[WW-1:WL]));
      hyb <= HW'(by5) * HW'($signed(wb[WW-1:WL]));
      hyc <= HW'(cy5) * HW'($signed(wc[WW-1:WL]));
      lxa <= LW'(ax5) * LW'($signed({1'b0, wa[WL-1:0]}));
      lxb <= LW'(bx5) * LW'($signed({1'b0, wb[WL-1:0]}));
      lxc <= LW'(cx5) * LW'($signed({1'b0, wc[WL-1:0]}));
      lya <= LW'(ay5) * LW'($signed({1'b0, wa[WL-1:0]}));
      lyb <= LW'(by5) * LW'($signed({1'b0, wb[WL-1:0]}));
      lyc <= LW'(cy5) * LW'($signed({1'b0, wc[WL-1:0]}));
      ph  <= XW'(sp[XW-1:SW]) * XW'(sca5);
      pl  <= XW'(sp[SW-1:0]) * XW'(sca5);
      n123_6 <= n123_5;
    end
  end

  // Numerators, doubled divisor and full side product
  always_ff @(posedge clk) begin
    if (en) begin
      numx <= ((UW'(hxa) + UW'(hxb) + UW'(hxc)) <<< WL) + UW'(lxa) + UW'(lxb) + UW'(lxc);
      numy <= ((UW'(hya) + UW'(hyb) + UW'(hyc)) <<< WL) + UW'(lya) + UW'(lyb) + UW'(lyc);
      den  <= {n123_6, 1'b0};
      p7   <= {ph, SW'(0)} + BW'(pl);
    end
  end

  // Magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      negx  <= numx[UW-1] ^ den[EW-1];
      negy  <= numy[UW-1] ^ den[EW-1];
      absx  <= numx[UW-1] ? UW'(-numx) : UW'(numx);
      absy  <= numy[UW-1] ? UW'(-numy) : UW'(numy);
      absd  <= den[EW-1] ? EW'(-den) : EW'(den);
      zero8 <= (den == '0);
      p8    <= p7;
    end
  end

  // Overflow checks and divider start values
  always_ff @(posedge clk) begin
    if (en) begin
      res.flags.zero  <= zero8;
      res.flags.neg_x <= negx;
      res.flags.neg_y <= negy;
      res.flags.ovf_x <= EW'(absx[UW-1:QW]) >= absd;
      res.flags.ovf_y <= EW'(absy[UW-1:QW]) >= absd;
      res.flags.ovf_r <= RW'(p8[BW-1:RQ]) >= {absd, 1'b0};
      res.dc    <= absd;
      res.x_rem <= EW'(absx[UW-1:QW]);
      res.x_sh  <= absx[QW-1:0];
      res.y_rem <= EW'(absy[UW-1:QW]);
      res.y_sh  <= absy[QW-1:0];
      res.r_rem <= RW'(p8[BW-1:RQ]);
      res.r_sh  <= p8[RQ-1:0];
      res.dr    <= {absd, 1'b0};
    end
  end

endmodule

`default_nettype wire

FILE: sv/tcc_div_cell.sv
// One restoring division step: shifts in a numerator bit, emits a quotient bit.
// Standalone; chained by the top level.
`default_nettype none

module tcc_div_cell #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] d,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [QW-1:0] sh_i,
  output logic      [DW-1:0] rem_o,
  output logic      [QW-1:0] sh_o
);

  logic [DW:0] t;
  logic        ge;

  // Trial subtract
  assign t  = {rem_i, sh_i[QW-1]};
  assign ge = (t >= {1'b0, d});

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
      sh_o  <= {sh_i[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: sv/tcc_sqrt_cell.sv
// One digit step of a floor square root: two radicand bits in, one root bit out.
// Standalone; chained by the top level.
`default_nettype none

module tcc_sqrt_cell #(
  parameter int XW = 64,
  parameter int RW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW+1:0] rem_i,
  input  wire logic [RW-1:0] root_i,
  input  wire logic [XW-1:0] x_i,
  output logic      [RW+1:0] rem_o,
  output logic      [RW-1:0] root_o,
  output logic      [XW-1:0] x_o
);

  logic [RW+3:0] t;
  logic [RW+3:0] trial;
  logic          ge;

  // Trial subtract of 4*root+1
  assign t     = {rem_i, x_i[XW-1:XW-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = (t >= trial);

  // Advance remainder, root and radicand
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? (RW+2)'(t - trial) : t[RW+1:0];
      root_o <= {root_i[RW-2:0], ge};
      x_o    <= {x_i[XW-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

FILE: sv/triangle_circumcircle.sv
// Top level of the triangle circumcircle block.
// Depends on tcc_pkg, tcc_front, tcc_div_cell, tcc_sqrt_cell and the assert header.
//
// Usage:
//   Request channel (req_valid, req_stall, req) carries three signed Q12.4
//   vertices. Response channel (rsp_valid, rsp_stall, rsp) returns one result
//   per request: validity, clip flag, Q28.4 circumcenter and circumradius.
//   A transfer happens on a rising edge with valid high and stall low.
// Request to response valid passes through 9 front arithmetic
//   stages, a row of 33 division cells for the center (x and y side by side),
//   64 division cells for the squared radius, 32 square root cells, and the
//   output register.
// Throughput: one request per cycle while the chain is not held; every cell
//   finishes its step and hands on to its neighbor.
// Reset clears all valid bits; data registers are not reset.
// When the receiver stalls a held response, the chain keeps moving while its
//   last stage is empty; once that stage is full too, the chain holds and
//   req_stall goes high.
`default_nettype none
`include "triangle_circumcircle_assert.svh"

module triangle_circumcircle (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire tcc_pkg::tcc_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output tcc_pkg::tcc_rsp_t      rsp
);

  localparam int EW   = tcc_pkg::DEN_W;
  localparam int QW   = tcc_pkg::CQ_W;
  localparam int RW   = tcc_pkg::RD_W;
  localparam int RQ   = tcc_pkg::RQ_W;
  localparam int TW   = tcc_pkg::ROOT_W;
  localparam int LAST = tcc_pkg::FRONT_STAGES + QW + RQ + TW;

  logic adv;
  logic load;
  logic [1:LAST] vld;
  tcc_pkg::tcc_front_t front;

  logic [EW-1:0] xr [0:QW-1];
  logic [QW-1:0] xs [0:QW];
  logic [EW-1:0] yr [0:QW-1];
  logic [QW-1:0] ys [0:QW];
  tcc_pkg::tcc_p1_t p1 [0:QW];

  logic [RW-1:0] rr [0:RQ-1];
  logic [RQ-1:0] rs [0:RQ];
  tcc_pkg::tcc_p2_t p2 [0:RQ];

  logic [TW+1:0] sm [0:TW-1];
  logic [TW-1:0] rt [0:TW];
  logic [RQ-1:0] sx [0:TW-1];
  tcc_pkg::tcc_p3_t p3 [0:TW];

  logic [tcc_pkg::OUT_W:0] fx, fy;
  tcc_pkg::tcc_rsp_t rsp_next;

  // Move the chain unless the output holds a stalled response and the last stage is full
  assign load      = !rsp_valid || !rsp_stall;
  assign adv       = load || !vld[LAST];
  assign req_stall = !adv;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {req_valid, vld[1:LAST-1]};
    end
  end

  tcc_front u_front (
    .clk (clk),
    .en  (adv),
    .req (req),
    .res (front)
  );

  // Center division row
  assign xr[0] = front.x_rem;
  assign xs[0] = front.x_sh;
  assign yr[0] = front.y_rem;
  assign ys[0] = front.y_sh;
  assign p1[0] = '{flags: front.flags, dc: front.dc, r_rem: front.r_rem,
                   r_sh: front.r_sh, dr: front.dr};

  for (genvar i = 0; i < QW; i++) begin : g_cdiv
    if (i < QW - 1) begin : g_mid
      tcc_div_cell #(.DW(EW), .QW(QW)) u_x (
        .clk(clk), .en(adv), .d(p1[i].dc), .rem_i(xr[i]), .sh_i(xs[i]),
        .rem_o(xr[i+1]), .sh_o(xs[i+1]));
      tcc_div_cell #(.DW(EW), .QW(QW)) u_y (
        .clk(clk), .en(adv), .d(p1[i].dc), .rem_i(yr[i]), .sh_i(ys[i]),
        .rem_o(yr[i+1]), .sh_o(ys[i+1]));
    end else begin : g_end
      tcc_div_cell #(.DW(EW), .QW(QW)) u_x (
        .clk(clk), .en(adv), .d(p1[i].dc), .rem_i(xr[i]), .sh_i(xs[i]),
        .rem_o(), .sh_o(xs[i+1]));
      tcc_div_cell #(.DW(EW), .QW(QW)) u_y (
        .clk(clk), .en(adv), .d(p1[i].dc), .rem_i(yr[i]), .sh_i(ys[i]),
        .rem_o(), .sh_o(ys[i+1]));
    end
    always_ff @(posedge clk) begin
      if (adv) p1[i+1] <= p1[i];
    end
  end

  // Radius division row
  assign rr[0] = p1[QW].r_rem;
  assign rs[0] = p1[QW].r_sh;
  assign p2[0] = '{flags: p1[QW].flags, qx: xs[QW], qy: ys[QW], dr: p1[QW].dr};

  for (genvar i = 0; i < RQ; i++) begin : g_rdiv
    if (i < RQ - 1) begin : g_mid
      tcc_div_cell #(.DW(RW), .QW(RQ)) u_r (
        .clk(clk), .en(adv), .d(p2[i].dr), .rem_i(rr[i]), .sh_i(rs[i]),
        .rem_o(rr[i+1]), .sh_o(rs[i+1]));
    end else begin : g_end
      tcc_div_cell #(.DW(RW), .QW(RQ)) u_r (
        .clk(clk), .en(adv), .d(p2[i].dr), .rem_i(rr[i]), .sh_i(rs[i]),
        .rem_o(), .sh_o(rs[i+1]));
    end
    always_ff @(posedge clk) begin
      if (adv) p2[i+1] <= p2[i];
    end
  end

  // Square root row
  assign sm[0] = '0;
  assign rt[0] = '0;
  assign sx[0] = rs[RQ];
  assign p3[0] = '{flags: p2[RQ].flags, qx: p2[RQ].qx, qy: p2[RQ].qy};

  for (genvar i = 0; i < TW; i++) begin : g_sqrt
    if (i < TW - 1) begin : g_mid
      tcc_sqrt_cell #(.XW(RQ), .RW(TW)) u_s (
        .clk(clk), .en(adv), .rem_i(sm[i]), .root_i(rt[i]), .x_i(sx[i]),
        .rem_o(sm[i+1]), .root_o(rt[i+1]), .x_o(sx[i+1]));
    end else begin : g_end
      tcc_sqrt_cell #(.XW(RQ), .RW(TW)) u_s (
        .clk(clk), .en(adv), .rem_i(sm[i]), .root_i(rt[i]), .x_i(sx[i]),
        .rem_o(), .root_o(rt[i+1]), .x_o());
    end
    always_ff @(posedge clk) begin
      if (adv) p3[i+1] <= p3[i];
    end
  end

  // Clip and assemble the response
  assign fx = tcc_pkg::sat_center(p3[TW].qx, p3[TW].flags.neg_x, p3[TW].flags.ovf_x);
  assign fy = tcc_pkg::sat_center(p3[TW].qy, p3[TW].flags.neg_y, p3[TW].flags.ovf_y);

  always_comb begin
    if (p3[TW].flags.zero) begin
      rsp_next = '0;
    end else begin
      rsp_next.is_valid  = 1'b1;
      rsp_next.saturated = fx[tcc_pkg::OUT_W] | fy[tcc_pkg::OUT_W] | p3[TW].flags.ovf_r;
      rsp_next.center_x  = fx[tcc_pkg::OUT_W-1:0];
      rsp_next.center_y  = fy[tcc_pkg::OUT_W-1:0];
      rsp_next.radius    = p3[TW].flags.ovf_r ? tcc_pkg::U32_MAX : rt[TW];
    end
  end

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (load) rsp <= rsp_next;
  end

  `TCC_ASSERT_IMP(a_collinear_zero, rsp_valid && !rsp.is_valid, (rsp.radius == '0 && rsp.center_x == '0 && rsp.center_y == '0 && !rsp.saturated), "collinear response carries nonzero fields")
  `TCC_ASSERT_NXT(a_chain_hold, !adv, $stable(vld), "valid chain moved while held")
  `TCC_ASSERT_IMP(a_rsp_source, $rose(rsp_valid), $past(vld[LAST]), "response appeared without a finished request")
  `TCC_ASSERT_NXT(a_radius_clip, (load && vld[LAST] && p3[TW].flags.ovf_r && !p3[TW].flags.zero), (rsp.saturated && rsp.radius == tcc_pkg::U32_MAX), "radius overflow not clipped")

endmodule

`default_nettype wire

FILE: test/triangle_circumcircle_test.sv
// Self-checking testbench for triangle_circumcircle: directed and random triangles.
// Depends on tcc_pkg and the triangle_circumcircle RTL; predicts each result
// with exact wide integer arithmetic.
`timescale 1ns / 1ps

module triangle_circumcircle_test;

  localparam int LATENCY = 139;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  tcc_pkg::tcc_req_t req;
  logic              rsp_valid;
  logic              rsp_stall;
  tcc_pkg::tcc_rsp_t rsp;

  tcc_pkg::tcc_rsp_t expected_circles[$];
  int       mismatches;
  int       send_idle_pct;
  int       rsp_stall_pct;
  int       hold_cycles;

  triangle_circumcircle i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Clip a truncated quotient to signed 32 bits
  function automatic logic [31:0] clip_center(input logic signed [255:0] num,
                                              input logic signed [255:0] den,
                                              inout logic sat);
    logic signed [255:0] q;
    logic neg;
    neg = (num < 0) != (den < 0);
    q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
    if (neg) begin
      if (q > 256'sh80000000) begin
        sat = 1'b1;
        return 32'h80000000;
      end
      return 32'(-q);
    end
    if (q > 256'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    return q[31:0];
  endfunction

  // Exact circumcenter and circumradius of one triangle
  function automatic tcc_pkg::tcc_rsp_t circumcircle(input tcc_pkg::tcc_req_t t);
    logic signed [255:0] ax, ay, bx, by, cx, cy;
    logic signed [255:0] dca, dba, dcb, n1, n2, n3, n123, den, numx, numy, prod, q, r, s;
    tcc_pkg::tcc_rsp_t o;
    logic sat;
    ax = t.point_a_x; ay = t.point_a_y;
    bx = t.point_b_x; by = t.point_b_y;
    cx = t.point_c_x; cy = t.point_c_y;
    dca = (cx - ax) * (bx - ax) + (cy - ay) * (by - ay);
    dba = (cx - bx) * (ax - bx) + (cy - by) * (ay - by);
    dcb = (ax - cx) * (bx - cx) + (ay - cy) * (by - cy);
    n1 = dba * dcb; n2 = dcb * dca; n3 = dca * dba;
    n123 = n1 + n2 + n3;
    o = '0;
    if (n123 == 0) return o;
    sat = 1'b0;
    den = 2 * n123;
    numx = ax * (n2 + n3) + bx * (n3 + n1) + cx * (n1 + n2);
    numy = ay * (n2 + n3) + by * (n3 + n1) + cy * (n1 + n2);
    o.center_x = clip_center(numx, den, sat);
    o.center_y = clip_center(numy, den, sat);
    prod = (dca + dba) * (dba + dcb) * (dcb + dca);
    q = (prod < 0 ? -prod : prod) / (n123 < 0 ? -4 * n123 : 4 * n123);
    r = 0;
    for (int b = 95; b >= 0; b--) begin
      s = r | (256'sd1 <<< b);
      if (s * s <= q) r = s;
    end
    if (r > 256'shFFFFFFFF) begin
      o.radius = 32'hFFFFFFFF;
      sat = 1'b1;
    end else begin
      o.radius = r[31:0];
    end
    o.is_valid = 1'b1;
    o.saturated = sat;
    return o;
  endfunction

  // Offer one request after a random idle gap; predict it once accepted.
  // Valid stays up after acceptance until the next falling edge, where the
  // next call either drops it or puts up the next request.
  task automatic send_triangle(input tcc_pkg::tcc_req_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_circles = {expected_circles, circumcircle(t)};
  endtask

  function automatic tcc_pkg::tcc_req_t make_triangle(input int ax, ay, bx, by, cx, cy);
    tcc_pkg::tcc_req_t t;
    t.point_a_x = 16'(ax); t.point_a_y = 16'(ay);
    t.point_b_x = 16'(bx); t.point_b_y = 16'(by);
    t.point_c_x = 16'(cx); t.point_c_y = 16'(cy);
    return t;
  endfunction

  // Pick a random triangle: full range, small, or nearly collinear
  function automatic tcc_pkg::tcc_req_t random_triangle();
    tcc_pkg::tcc_req_t t;
    int kind, k;
    kind = $urandom_range(9);
    t = tcc_pkg::tcc_req_t'({$urandom, $urandom, $urandom});
    if (kind < 3) begin
      t.point_a_x = 16'($urandom_range(64) - 32); t.point_a_y = 16'($urandom_range(64) - 32);
      t.point_b_x = 16'($urandom_range(64) - 32); t.point_b_y = 16'($urandom_range(64) - 32);
      t.point_c_x = 16'($urandom_range(64) - 32); t.point_c_y = 16'($urandom_range(64) - 32);
    end else if (kind < 6) begin
      k = $urandom_range(6) - 3;
      t.point_a_x = 16'($urandom_range(2000) - 1000); t.point_a_y = 16'($urandom_range(2000) - 1000);
      t.point_b_x = 16'($urandom_range(2000) - 1000); t.point_b_y = 16'($urandom_range(2000) - 1000);
      t.point_c_x = 16'(t.point_a_x + k * (t.point_b_x - t.point_a_x) + $urandom_range(2) - 1);
      t.point_c_y = 16'(t.point_a_y + k * (t.point_b_y - t.point_a_y) + $urandom_range(2) - 1);
    end
    return t;
  endfunction

  // Drive the response stall: long hold when requested, else random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    tcc_pkg::tcc_rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_circles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp);
      end else begin
        e = expected_circles.pop_front();
        if (rsp.is_valid !== e.is_valid || rsp.saturated !== e.saturated ||
            rsp.center_x !== e.center_x || rsp.center_y !== e.center_y ||
            rsp.radius !== e.radius) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, rsp);
        end
      end
    end
  end

  task automatic test_directed();
    tcc_pkg::tcc_req_t t;
    send_idle_pct = 0; rsp_stall_pct = 0;
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0));
    send_triangle(make_triangle(5, 5, 5, 5, 9, -3));
    send_triangle(make_triangle(0, 0, 16, 16, 32, 32));
    send_triangle(make_triangle(0, 0, 160, 0, 0, 160));
    send_triangle(make_triangle(-32768, -32768, 32767, -32768, 0, 32767));
    send_triangle(make_triangle(32767, 32767, -32768, 32767, 32767, -32768));
    send_triangle(make_triangle(-32768, -32768, 32767, 32767, -32768, 32767));
    send_triangle(make_triangle(-32768, 0, 32767, 0, 0, 1));
    send_triangle(make_triangle(-32768, -32768, 32767, 32767, 32767, 32766));
    send_triangle(make_triangle(-32768, 0, 0, 1, 32767, 0));
    send_triangle(make_triangle(0, 0, 1, 0, 0, 1));
    send_triangle(make_triangle(-1, -1, -1, 1, 1, -1));
    send_triangle(make_triangle(100, -200, -300, 400, 500, 600));
    t = make_triangle(-32768, 32767, 32767, -32768, 0, 0);
    send_triangle(t);
    send_triangle(make_triangle(32767, 32767, 32767, 32767, 32767, 32767));
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct; rsp_stall_pct = stall_pct;
    repeat (count) send_triangle(random_triangle());
  endtask

  // Hold the receiver off while requests keep coming so the chain fills
  task automatic test_backpressure();
    send_idle_pct = 0; rsp_stall_pct = 0;
    hold_cycles = 3 * LATENCY;
    repeat (300) send_triangle(random_triangle());
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    hold_cycles = 0;
    mismatches = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(350, 0, 0);
    test_random(250, 85, 0);
    test_random(250, 0, 85);
    test_random(250, 31, 31);
    test_backpressure();
    test_random(150, 0, 0);
    // Drop the last request once it is taken
    @(negedge clk);
    req_valid <= 1'b0;
    rsp_stall_pct = 0;
    while (expected_circles.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_circles.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
